>>> rtl/wpmd_pkg.sv
// Package for the wheel PID motor drive: register indexes, field widths and
// constants for the duty and PWM scaling. No dependencies.
`default_nettype none

package wpmd_pkg;

   localparam int CountWidth  = 32;
   localparam int TargetWidth = 24;
   localparam int GainWidth   = 16;
   localparam int DutyWidth   = 7;
   localparam int PwmWidth    = 14;
   localparam int CsrWidth    = 16;
   localparam int CsrIdxWidth = 3;

   localparam int ErrWidth  = CountWidth + 1;
   localparam int ProdWidth = GainWidth + ErrWidth;
   localparam int SumWidth  = ProdWidth + 1;
   localparam int MagWidth  = SumWidth - 8;

   localparam int StageCount = 6;

   localparam logic [DutyWidth-1:0] DutyFull = 7'd100;

   // floor(mag * 8192 / 100) == (mag * PwmRecip) >> PwmShift for mag <= 127
   localparam int PwmRecipWidth = 20;
   localparam int PwmShift      = 13;
   localparam logic [PwmRecipWidth-1:0] PwmRecip = 20'd671089;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CONTROL_MODE   = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_ENCODER_NEGATE = 3'd4,
      CSR_MOTOR_NEGATE   = 3'd5,
      CSR_DUTY_LIMIT     = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

>>> rtl/wheel_pid_motor_drive.sv
// Wheel PID motor drive: one request per sample tick, six-stage pipeline
// from encoder count and target to direction, duty and PWM compare value.
// Depends on wpmd_pkg.
// Throughput: one request per cycle while the output is not stalled; each stage is a register of the pipeline.
// Reset: synchronous; clears stage valids, previous count, error integral and
// all control registers (duty_limit resets to 100).
`default_nettype none

module wheel_pid_motor_drive (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          req_valid,
   output logic                                         req_ready,
   input  wire  logic signed [wpmd_pkg::CountWidth-1:0]  req_encoder_count,
   input  wire  logic signed [wpmd_pkg::TargetWidth-1:0] req_target,
   output logic                                         rsp_valid,
   input  wire                                          rsp_ready,
   output logic                                         rsp_forward,
   output logic [wpmd_pkg::PwmWidth-1:0]                rsp_pwm_compare,
   output logic [wpmd_pkg::DutyWidth-1:0]               rsp_duty_magnitude,
   output logic signed [wpmd_pkg::CountWidth-1:0]       rsp_measured_rate,
   input  wire                                          csr_we,
   input  wire  logic [wpmd_pkg::CsrIdxWidth-1:0]       csr_index,
   input  wire  logic [wpmd_pkg::CsrWidth-1:0]          csr_wdata
);

   localparam int CW = wpmd_pkg::CountWidth;
   localparam int TW = wpmd_pkg::TargetWidth;
   localparam int GW = wpmd_pkg::GainWidth;
   localparam int EW = wpmd_pkg::ErrWidth;
   localparam int PW = wpmd_pkg::ProdWidth;
   localparam int SW = wpmd_pkg::SumWidth;
   localparam int MW = wpmd_pkg::MagWidth;
   localparam int DW = wpmd_pkg::DutyWidth;
   localparam int NS = wpmd_pkg::StageCount;
   localparam int RW = DW + wpmd_pkg::PwmRecipWidth;

   localparam logic signed [CW-1:0] CountMax = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CountMin = {1'b1, {(CW-1){1'b0}}};

   function automatic logic signed [CW-1:0] sat_count(input logic signed [CW+1:0] v);
      logic signed [CW-1:0] r;
      if (v[CW+1:CW-1] == 3'b000 || v[CW+1:CW-1] == 3'b111) begin
         r = v[CW-1:0];
      end else if (v[CW+1]) begin
         r = CountMin;
      end else begin
         r = CountMax;
      end
      return r;
   endfunction

   // control registers
   logic                 mode_ff;
   logic signed [GW-1:0] gain_p_ff;
   logic signed [GW-1:0] gain_i_ff;
   logic signed [GW-1:0] gain_d_ff;
   logic                 enc_neg_ff;
   logic                 mot_neg_ff;
   logic [DW-1:0]        duty_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         enc_neg_ff    <= 1'b0;
         mot_neg_ff    <= 1'b0;
         duty_limit_ff <= wpmd_pkg::DutyFull;
      end else if (csr_we) begin
         unique case (wpmd_pkg::csr_index_type'(csr_index))
            wpmd_pkg::CSR_CONTROL_MODE:   mode_ff       <= csr_wdata[0];
            wpmd_pkg::CSR_GAIN_P:         gain_p_ff     <= csr_wdata;
            wpmd_pkg::CSR_GAIN_I:         gain_i_ff     <= csr_wdata;
            wpmd_pkg::CSR_GAIN_D:         gain_d_ff     <= csr_wdata;
            wpmd_pkg::CSR_ENCODER_NEGATE: enc_neg_ff    <= csr_wdata[0];
            wpmd_pkg::CSR_MOTOR_NEGATE:   mot_neg_ff    <= csr_wdata[0];
            wpmd_pkg::CSR_DUTY_LIMIT:     duty_limit_ff <= csr_wdata[DW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow control
   logic [NS-1:0] stage_valid_ff;
   logic [NS-1:0] stage_ready;
   logic [NS-1:0] stage_load;
   logic [NS-1:0] upstream_valid;

   always_comb begin
      upstream_valid = {stage_valid_ff[NS-2:0], req_valid};
      stage_ready[NS-1] = !stage_valid_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_ready[i] = !stage_valid_ff[i] || stage_ready[i+1];
      end
      stage_load = stage_ready & upstream_valid;
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = stage_valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (stage_ready[i]) begin
               stage_valid_ff[i] <= upstream_valid[i];
            end
         end
      end
   end

   // stage 1: count with sign applied
   logic signed [CW-1:0] s1_count_ff, s1_count_in;
   logic signed [TW-1:0] s1_target_ff;

   always_comb begin
      if (!enc_neg_ff) begin
         s1_count_in = req_encoder_count;
      end else if (req_encoder_count == CountMin) begin
         s1_count_in = CountMax;
      end else begin
         s1_count_in = -req_encoder_count;
      end
   end

   // stage 2: rate against previous count
   logic signed [CW-1:0] prev_count_ff;
   logic signed [CW-1:0] s2_count_ff;
   logic signed [TW-1:0] s2_target_ff;
   logic signed [CW-1:0] s2_rate_ff, s2_rate_in;

   assign s2_rate_in = sat_count((CW+2)'(s1_count_ff) - (CW+2)'(prev_count_ff));

   // stage 3: control error
   logic signed [EW-1:0] s3_err_ff, s3_err_in;
   logic signed [CW-1:0] s3_rate_ff;

   assign s3_err_in = mode_ff ? (EW'(s2_target_ff) - EW'(s2_count_ff))
                              : (EW'(s2_target_ff) - EW'(s2_rate_ff));

   // stage 4: gain products, integral update
   logic signed [CW-1:0] integral_ff, integral_in;
   logic signed [PW-1:0] s4_prod_p_ff, s4_prod_p_in;
   logic signed [PW-1:0] s4_prod_d_ff, s4_prod_d_in;
   logic signed [PW-1:0] s4_prod_i_ff, s4_prod_i_in;
   logic signed [CW-1:0] s4_rate_ff;
   logic signed [GW-1:0] gain_d_eff;

   assign gain_d_eff   = mode_ff ? gain_d_ff : '0;
   assign s4_prod_p_in = PW'(gain_p_ff) * PW'(s3_err_ff);
   assign s4_prod_d_in = PW'(gain_d_eff) * PW'(s3_rate_ff);
   assign s4_prod_i_in = PW'(gain_i_ff) * PW'(integral_ff);
   assign integral_in  = sat_count((CW+2)'(integral_ff) + (CW+2)'(s3_err_ff));

   // stage 5: sum of products
   logic signed [SW-1:0] s5_sum_ff, s5_sum_in;
   logic signed [CW-1:0] s5_rate_ff;

   assign s5_sum_in = SW'(s4_prod_p_ff) - SW'(s4_prod_d_ff) + SW'(s4_prod_i_ff);

   // stage 6: direction, clamp, PWM scale
   logic [SW-1:0] sum_abs;
   logic [MW-1:0] mag_abs;
   logic [DW-1:0] limit_eff;
   logic [DW-1:0] mag_in;
   logic [RW-1:0] pwm_prod;
   logic          fwd_in;
   logic          fwd_ff;
   logic [wpmd_pkg::PwmWidth-1:0] pwm_ff;
   logic [DW-1:0] mag_ff;
   logic signed [CW-1:0] s6_rate_ff;

   always_comb begin
      sum_abs   = s5_sum_ff[SW-1] ? SW'(-s5_sum_ff) : SW'(s5_sum_ff);
      mag_abs   = sum_abs[SW-1:8];
      limit_eff = (duty_limit_ff > wpmd_pkg::DutyFull) ? wpmd_pkg::DutyFull : duty_limit_ff;
      mag_in    = (mag_abs > MW'(limit_eff)) ? limit_eff : mag_abs[DW-1:0];
      fwd_in    = (mag_abs == '0) || !(s5_sum_ff[SW-1] ^ mot_neg_ff);
      pwm_prod  = RW'(mag_in) * RW'(wpmd_pkg::PwmRecip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         integral_ff   <= '0;
      end else begin
         if (stage_load[1]) begin
            prev_count_ff <= s1_count_ff;
         end
         if (stage_load[3]) begin
            integral_ff <= integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         s1_count_ff  <= s1_count_in;
         s1_target_ff <= req_target;
      end
      if (stage_load[1]) begin
         s2_count_ff  <= s1_count_ff;
         s2_target_ff <= s1_target_ff;
         s2_rate_ff   <= s2_rate_in;
      end
      if (stage_load[2]) begin
         s3_err_ff  <= s3_err_in;
         s3_rate_ff <= s2_rate_ff;
      end
      if (stage_load[3]) begin
         s4_prod_p_ff <= s4_prod_p_in;
         s4_prod_d_ff <= s4_prod_d_in;
         s4_prod_i_ff <= s4_prod_i_in;
         s4_rate_ff   <= s3_rate_ff;
      end
      if (stage_load[4]) begin
         s5_sum_ff  <= s5_sum_in;
         s5_rate_ff <= s4_rate_ff;
      end
      if (stage_load[5]) begin
         fwd_ff     <= fwd_in;
         pwm_ff     <= pwm_prod[wpmd_pkg::PwmShift +: wpmd_pkg::PwmWidth];
         mag_ff     <= mag_in;
         s6_rate_ff <= s5_rate_ff;
      end
   end

   assign rsp_forward        = fwd_ff;
   assign rsp_pwm_compare    = pwm_ff;
   assign rsp_duty_magnitude = mag_ff;
   assign rsp_measured_rate  = s6_rate_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> stage_valid_ff[0])
      else $error("accepted request not captured in first stage");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty_magnitude <= wpmd_pkg::DutyFull))
      else $error("duty magnitude above full scale");

   a_pwm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pwm_compare == '0) == (rsp_duty_magnitude == '0)))
      else $error("PWM compare and duty magnitude disagree on zero");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for wheel_pid_motor_drive: a clocked driver and monitor
// around the block, with an in-bench model of the PI/PID duty law.
// Depends on wpmd_pkg and the wheel_pid_motor_drive RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam int CountWidth  = wpmd_pkg::CountWidth;
   localparam int TargetWidth = wpmd_pkg::TargetWidth;
   localparam int PwmWidth    = wpmd_pkg::PwmWidth;
   localparam int DutyWidth   = wpmd_pkg::DutyWidth;
   localparam int CsrWidth    = wpmd_pkg::CsrWidth;
   localparam int CsrIdxWidth = wpmd_pkg::CsrIdxWidth;

   localparam int CycleLimit = 200000;
   localparam longint S32Max = 64'sd2147483647;
   localparam longint S32Min = -64'sd2147483648;

   typedef struct packed {
      logic signed [CountWidth-1:0]  encoder_count;
      logic signed [TargetWidth-1:0] target;
   } tick_type;

   typedef struct packed {
      logic                         forward;
      logic [PwmWidth-1:0]          pwm_compare;
      logic [DutyWidth-1:0]         duty_magnitude;
      logic signed [CountWidth-1:0] measured_rate;
   } drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic signed [CountWidth-1:0] req_encoder_count = '0;
   logic signed [TargetWidth-1:0] req_target = '0;
   logic rsp_ready = 1'b0;
   logic csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrWidth-1:0] csr_wdata = '0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_forward;
   logic [PwmWidth-1:0] rsp_pwm_compare;
   logic [DutyWidth-1:0] rsp_duty_magnitude;
   logic signed [CountWidth-1:0] rsp_measured_rate;

   tick_type tick_q[$];
   drive_type drive_expected_q[$];
   int send_idle_pct = 36;
   int recv_idle_pct = 47;
   int sent_count = 0;
   int resp_count = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int setting_count = 0;

   // mirrored configuration and controller state
   logic m_control_mode = 1'b0;
   longint m_gain_p = 0;
   longint m_gain_i = 0;
   longint m_gain_d = 0;
   logic m_encoder_negate = 1'b0;
   logic m_motor_negate = 1'b0;
   longint m_duty_limit = 100;
   longint m_prev_count = 0;
   longint m_integral = 0;

   wheel_pid_motor_drive u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_encoder_count  (req_encoder_count),
      .req_target         (req_target),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_forward        (rsp_forward),
      .rsp_pwm_compare    (rsp_pwm_compare),
      .rsp_duty_magnitude (rsp_duty_magnitude),
      .rsp_measured_rate  (rsp_measured_rate),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_s32(longint v);
      if (v > S32Max) return S32Max;
      if (v < S32Min) return S32Min;
      return v;
   endfunction

   function automatic drive_type compute_drive(logic signed [CountWidth-1:0] enc,
                                               logic signed [TargetWidth-1:0] tgt);
      longint pos, goal, rate, err, sum, duty, mag, lim, pwm;
      drive_type r;
      pos = enc;
      goal = tgt;
      if (m_encoder_negate) pos = clamp_s32(-pos);
      rate = clamp_s32(pos - m_prev_count);
      m_prev_count = pos;
      if (m_control_mode) begin
         err = goal - pos;
         sum = m_gain_p * err - m_gain_d * rate + m_gain_i * m_integral;
      end else begin
         err = goal - rate;
         sum = m_gain_p * err + m_gain_i * m_integral;
      end
      m_integral = clamp_s32(m_integral + err);
      duty = sum / 256;
      if (m_motor_negate) duty = -duty;
      r.forward = (duty >= 0);
      mag = (duty < 0) ? -duty : duty;
      lim = (m_duty_limit > 100) ? 100 : m_duty_limit;
      if (mag > lim) mag = lim;
      pwm = (mag * 8192) / 100;
      r.pwm_compare = pwm[PwmWidth-1:0];
      r.duty_magnitude = mag[DutyWidth-1:0];
      r.measured_rate = rate[CountWidth-1:0];
      return r;
   endfunction

   function automatic logic [CsrWidth-1:0] pick_gain(int lo, int hi);
      int mag;
      mag = int'($urandom_range(hi, lo));
      return ($urandom_range(1, 0) == 1) ? CsrWidth'(-mag) : CsrWidth'(mag);
   endfunction

   always @(posedge clock) begin : driver
      tick_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            drive_expected_q.push_back(compute_drive(req_encoder_count, req_target));
         if (!req_valid || req_ready) begin
            if (tick_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               cur = tick_q.pop_front();
               req_valid <= 1'b1;
               req_encoder_count <= cur.encoder_count;
               req_target <= cur.target;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      drive_type exp_drive;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            resp_count++;
            if (drive_expected_q.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               exp_drive = drive_expected_q.pop_front();
               if (rsp_forward !== exp_drive.forward) begin
                  $error("forward: expected %0d, got %0d", exp_drive.forward, rsp_forward);
                  fail_count++;
               end
               if (rsp_pwm_compare !== exp_drive.pwm_compare) begin
                  $error("pwm_compare: expected %0d, got %0d",
                         exp_drive.pwm_compare, rsp_pwm_compare);
                  fail_count++;
               end
               if (rsp_duty_magnitude !== exp_drive.duty_magnitude) begin
                  $error("duty_magnitude: expected %0d, got %0d",
                         exp_drive.duty_magnitude, rsp_duty_magnitude);
                  fail_count++;
               end
               if (rsp_measured_rate !== exp_drive.measured_rate) begin
                  $error("measured_rate: expected %0d, got %0d",
                         exp_drive.measured_rate, rsp_measured_rate);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_tick(logic [CountWidth-1:0] enc, logic [TargetWidth-1:0] tgt);
      tick_type t;
      t.encoder_count = enc;
      t.target = tgt;
      tick_q.push_back(t);
      sent_count++;
   endtask

   task automatic wait_drained();
      while (resp_count < sent_count) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(wpmd_pkg::csr_index_type idx, logic [CsrWidth-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      unique case (idx)
         wpmd_pkg::CSR_CONTROL_MODE:   m_control_mode = val[0];
         wpmd_pkg::CSR_GAIN_P:         m_gain_p = $signed(val);
         wpmd_pkg::CSR_GAIN_I:         m_gain_i = $signed(val);
         wpmd_pkg::CSR_GAIN_D:         m_gain_d = $signed(val);
         wpmd_pkg::CSR_ENCODER_NEGATE: m_encoder_negate = val[0];
         wpmd_pkg::CSR_MOTOR_NEGATE:   m_motor_negate = val[0];
         wpmd_pkg::CSR_DUTY_LIMIT:     m_duty_limit = val[DutyWidth-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // drive the shared integral back to zero with angle-mode requests
   task automatic unwind_integral();
      longint raw;
      if (m_integral != 0 && !m_control_mode) write_csr(wpmd_pkg::CSR_CONTROL_MODE, 16'd1);
      while (m_integral != 0) begin
         raw = m_encoder_negate ? -m_integral : m_integral;
         if (raw > S32Max) raw = S32Max;
         queue_tick(raw[CountWidth-1:0], '0);
         wait_drained();
      end
   endtask

   task automatic run_setting(int seg);
      longint pos, aim;
      logic mode;
      logic [CsrWidth-1:0] lim;
      unwind_integral();
      mode = 1'($urandom_range(1, 0));
      case (seg % 4)
         0: lim = 16'd100;
         1: lim = 16'd0;
         2: lim = 16'd127;
         default: lim = CsrWidth'($urandom_range(99, 1));
      endcase
      write_csr(wpmd_pkg::CSR_CONTROL_MODE, {15'd0, mode});
      write_csr(wpmd_pkg::CSR_GAIN_P, mode ? pick_gain(64, 512) : pick_gain(64, 1024));
      write_csr(wpmd_pkg::CSR_GAIN_I, mode ? pick_gain(0, 16) : pick_gain(0, 64));
      write_csr(wpmd_pkg::CSR_GAIN_D, pick_gain(64, 512));
      write_csr(wpmd_pkg::CSR_ENCODER_NEGATE, CsrWidth'($urandom_range(1, 0)));
      write_csr(wpmd_pkg::CSR_MOTOR_NEGATE, CsrWidth'($urandom_range(1, 0)));
      write_csr(wpmd_pkg::CSR_DUTY_LIMIT, lim);
      setting_count++;
      pos = longint'($urandom_range(8388607, 0)) - 4194304;
      repeat (40) begin
         pos = pos + $urandom_range(60, 0) - 30;
         if (mode) begin
            aim = (m_encoder_negate ? -pos : pos) + $urandom_range(400, 0) - 200;
         end else begin
            aim = longint'($urandom_range(80, 0)) - 40;
         end
         queue_tick(pos[CountWidth-1:0], aim[TargetWidth-1:0]);
      end
      repeat (10) begin
         case ($urandom_range(3, 0))
            0: queue_tick(32'h7fff_ffff, TargetWidth'($urandom));
            1: queue_tick(32'h8000_0000, TargetWidth'($urandom));
            default: queue_tick($urandom, TargetWidth'($urandom));
         endcase
      end
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: zero gains give zero duty; rate saturates both ways
      queue_tick(32'h0000_0000, 24'h00_0000);
      queue_tick(32'h7fff_ffff, 24'h7f_ffff);
      queue_tick(32'h8000_0000, 24'h80_0000);
      queue_tick(32'h7fff_ffff, 24'h00_0000);
      wait_drained();

      write_csr(wpmd_pkg::CSR_GAIN_P, 16'h7fff);
      write_csr(wpmd_pkg::CSR_GAIN_I, 16'h8000);
      write_csr(wpmd_pkg::CSR_GAIN_D, 16'h7fff);
      write_csr(wpmd_pkg::CSR_ENCODER_NEGATE, 16'd1);
      write_csr(wpmd_pkg::CSR_MOTOR_NEGATE, 16'd1);
      write_csr(wpmd_pkg::CSR_DUTY_LIMIT, 16'd127);
      write_csr(wpmd_pkg::CSR_CONTROL_MODE, 16'd1);
      setting_count++;
      queue_tick(32'h8000_0000, 24'h7f_ffff);
      queue_tick(32'h8000_0000, 24'h80_0000);
      queue_tick(32'h7fff_ffff, 24'h80_0000);
      queue_tick(32'h7fff_ffff, 24'h80_0000);
      queue_tick(32'h0000_0000, 24'h00_0000);
      wait_drained();

      write_csr(wpmd_pkg::CSR_CONTROL_MODE, 16'd0);
      write_csr(wpmd_pkg::CSR_GAIN_P, 16'h8000);
      write_csr(wpmd_pkg::CSR_GAIN_I, 16'h0001);
      write_csr(wpmd_pkg::CSR_ENCODER_NEGATE, 16'd0);
      write_csr(wpmd_pkg::CSR_MOTOR_NEGATE, 16'd0);
      write_csr(wpmd_pkg::CSR_DUTY_LIMIT, 16'd0);
      setting_count++;
      queue_tick(32'h1234_5678, 24'h00_0100);
      queue_tick(32'hffff_ff00, 24'h7f_ffff);
      queue_tick(32'h8000_0001, 24'h80_0001);
      queue_tick(32'h8000_0001, 24'h00_0000);
      wait_drained();

      // small angle errors in both directions, some inside the limit and one clamped to it
      write_csr(wpmd_pkg::CSR_CONTROL_MODE, 16'd1);
      write_csr(wpmd_pkg::CSR_GAIN_P, 16'h0100);
      write_csr(wpmd_pkg::CSR_GAIN_I, 16'h0000);
      write_csr(wpmd_pkg::CSR_GAIN_D, 16'h0000);
      write_csr(wpmd_pkg::CSR_DUTY_LIMIT, 16'd55);
      setting_count++;
      queue_tick(32'd10, 24'd50);
      queue_tick(32'd10, -24'sd20);
      queue_tick(32'd0, 24'd99);
      queue_tick(32'd0, 24'd0);
      wait_drained();
      write_csr(wpmd_pkg::CSR_MOTOR_NEGATE, 16'd1);
      write_csr(wpmd_pkg::CSR_DUTY_LIMIT, 16'd100);
      setting_count++;
      queue_tick(32'd5, 24'd45);
      queue_tick(-32'sd7, -24'sd100);
      queue_tick(-32'sd7, -24'sd7);
      wait_drained();

      for (int seg = 0; seg < 10; seg++) begin
         if (seg == 4) begin
            send_idle_pct = 47;
            recv_idle_pct = 36;
         end else if (seg == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_setting(seg);
      end

      wait_drained();
      if (drive_expected_q.size() != 0) begin
         $error("%0d expected responses never arrived", drive_expected_q.size());
         fail_count++;
      end
      $display("Run covered %0d requests and %0d responses across %0d register settings,",
               sent_count, resp_count, setting_count);
      $display("velocity and angle modes, saturation and clamping, with and without stalls.");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
